### sv/rcfa_pkg.sv
package rcfa_pkg;

    localparam logic [2:0] CMD_ALLOC = 3'd0;
    localparam logic [2:0] CMD_FREE  = 3'd1;
    localparam logic [2:0] CMD_REF   = 3'd2;
    localparam logic [2:0] CMD_QUERY = 3'd3;
    localparam logic [2:0] CMD_INIT  = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OOM     = 3'd1;
    localparam logic [2:0] ST_IGNORED = 3'd2;
    localparam logic [2:0] ST_NOT_ALC = 3'd3;
    localparam logic [2:0] ST_SAT     = 3'd4;

    localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] REG_RESERVED    = 2'd1;
    localparam logic [1:0] REG_LOW_GUARD   = 2'd2;

    localparam logic [15:0] RST_FRAME_COUNT = 16'd32768;
    localparam logic [15:0] RST_RESERVED    = 16'd1024;
    localparam logic [15:0] RST_LOW_GUARD   = 16'd256;

    localparam logic [7:0]  CNT_MAX = 8'hFF;
    localparam logic [15:0] TOT_MAX = 16'hFFFF;
    localparam logic [31:0] ADDR_NONE = 32'hFFFF_FFFF;
    localparam logic [27:0] FB_MAX = 28'hFFF_FFFF;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_SCAN_RD  = 7'b0000100,
        S_SCAN_CHK = 7'b0001000,
        S_ALLOC_WR = 7'b0010000,
        S_LOOK     = 7'b0100000,
        S_EXEC     = 7'b1000000
    } t_state;

endpackage

### sv/rcfa_ram.sv
module rcfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/refcounted_frame_allocator.sv
// Free, add reference and query: look and execute states, then the result register.
// Alloc: read and check per bitmap word from the hint word, then the write state.
// One transaction is worked at a time; the result register frees the input side.
// Reset and reinitialize sweep all MAX_FRAMES owner-count entries one per cycle,
// with input stalled; configuration writes are taken throughout.
module refcounted_frame_allocator #(
    parameter int MAX_FRAMES = 32768,
    parameter int PAGE_BYTES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_addr,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_frame_addr,
    output logic [7:0]  o_ref_count,
    output logic [27:0] o_free_bytes,
    output logic [15:0] o_shared_frames
);

    localparam int NWORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int FW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int WB_W   = $clog2(WORD_BITS);
    localparam int PG_W   = $clog2(PAGE_BYTES);
    localparam logic [FW-1:0] LAST_IDX = FW'(MAX_FRAMES - 1);
    localparam logic [WORD_BITS-1:0] WORD_FULL = '1;

    rcfa_pkg::t_state r_state, n_state;

    logic [15:0] r_frame_count, r_reserved, r_low_guard;
    logic [15:0] r_sw_fc, r_sw_rs, n_sw_fc, n_sw_rs;
    logic        r_init_rsp, n_init_rsp;
    logic [FW-1:0] r_idx, n_idx;
    logic [2:0]  r_cmd, n_cmd;
    logic [31:0] r_frame, n_frame;
    logic [NW_W:0] r_w, n_w;
    logic [NW_W:0] r_hint, n_hint;
    logic [31:0] r_nf, n_nf;
    logic [15:0] r_used, n_used;
    logic [15:0] r_shared, n_shared;
    logic        r_done, n_done;
    logic [2:0]  r_st, n_st;
    logic [31:0] r_fa, n_fa;
    logic [7:0]  r_rc, n_rc;
    logic        r_ovalid;
    logic [2:0]  r_o_st;
    logic [31:0] r_o_fa;
    logic [7:0]  r_o_rc;
    logic [27:0] r_o_fb;
    logic [15:0] r_o_sh;

    logic [15:0] fc, rs;
    logic [31:0] wlim;
    logic [FW-1:0] fidx;
    logic [NW_W-1:0] fword;
    logic [WB_W-1:0] fbit;
    logic [WB_W-1:0] zpos;
    logic        zfound;
    logic [WORD_BITS-1:0] sweep_word;

    logic                 bm_we;
    logic [NW_W-1:0]      bm_waddr, bm_raddr;
    logic [WORD_BITS-1:0] bm_wdata, bm_rdata;
    logic                 ct_we;
    logic [FW-1:0]        ct_waddr, ct_raddr;
    logic [7:0]           ct_wdata, ct_rdata;

    logic        in_fc, out_rng;
    logic [7:0]  c0;
    logic [15:0] fb_diff;
    logic [47:0] fb_wide;
    logic        load_out;

    rcfa_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS), .AW(NW_W)) u_bitmap (
        .i_clk(i_clk), .i_we(bm_we), .i_waddr(bm_waddr), .i_wdata(bm_wdata),
        .i_raddr(bm_raddr), .o_rdata(bm_rdata)
    );

    rcfa_ram #(.WIDTH(8), .DEPTH(MAX_FRAMES), .AW(FW)) u_counts (
        .i_clk(i_clk), .i_we(ct_we), .i_waddr(ct_waddr), .i_wdata(ct_wdata),
        .i_raddr(ct_raddr), .o_rdata(ct_rdata)
    );

    assign fc = (32'(r_frame_count) < MAX_FRAMES) ? r_frame_count : 16'(MAX_FRAMES);
    assign rs = (r_reserved < fc) ? r_reserved : fc;
    assign wlim = (32'(fc) + 32'(WORD_BITS - 1)) >> WB_W;
    assign fidx = r_frame[FW-1:0];
    assign fword = NW_W'(fidx >> WB_W);
    assign fbit = fidx[WB_W-1:0];
    assign in_fc = r_frame < 32'(fc);
    assign out_rng = (r_frame < 32'(r_low_guard)) || !in_fc;
    assign c0 = (ct_rdata == 8'd0) ? 8'd1 : ct_rdata;

    always_comb begin
        zpos = '0;
        zfound = 1'b0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!bm_rdata[j]) begin
                zpos = WB_W'(j);
                zfound = 1'b1;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            sweep_word[j] = ((32'(r_idx) + 32'(j)) < 32'(r_sw_rs))
                         || ((32'(r_idx) + 32'(j)) >= 32'(r_sw_fc));
        end
    end

    assign bm_raddr = (r_state == rcfa_pkg::S_SCAN_RD) ? r_w[NW_W-1:0] : fword;
    assign ct_raddr = (r_state == rcfa_pkg::S_SCAN_CHK) ? FW'(n_nf) : fidx;
    assign load_out = r_done && (!r_ovalid || !i_out_stall);
    assign o_in_stall = (r_state != rcfa_pkg::S_IDLE) || r_done;

    always_comb begin
        n_state = r_state;
        n_sw_fc = r_sw_fc;
        n_sw_rs = r_sw_rs;
        n_init_rsp = r_init_rsp;
        n_idx = r_idx;
        n_cmd = r_cmd;
        n_frame = r_frame;
        n_w = r_w;
        n_hint = r_hint;
        n_nf = r_nf;
        n_used = r_used;
        n_shared = r_shared;
        n_done = r_done && !load_out;
        n_st = r_st;
        n_fa = r_fa;
        n_rc = r_rc;
        bm_we = 1'b0;
        bm_waddr = fword;
        bm_wdata = bm_rdata;
        ct_we = 1'b0;
        ct_waddr = fidx;
        ct_wdata = ct_rdata;
        case (r_state)
            rcfa_pkg::S_CLEAR: begin
                ct_we = 1'b1;
                ct_waddr = r_idx;
                ct_wdata = (32'(r_idx) < 32'(r_sw_rs)) ? 8'd1 : 8'd0;
                bm_we = (r_idx[WB_W-1:0] == '0);
                bm_waddr = NW_W'(r_idx >> WB_W);
                bm_wdata = sweep_word;
                n_idx = r_idx + FW'(1);
                if (r_idx == LAST_IDX) begin
                    n_idx = '0;
                    n_hint = (NW_W + 1)'(r_sw_rs >> WB_W);
                    n_used = r_sw_rs;
                    n_shared = '0;
                    n_state = rcfa_pkg::S_IDLE;
                    if (r_init_rsp) begin
                        n_done = 1'b1;
                        n_st = rcfa_pkg::ST_OK;
                        n_fa = '0;
                        n_rc = '0;
                    end
                end
            end
            rcfa_pkg::S_IDLE: begin
                if (i_in_valid && !r_done) begin
                    n_cmd = i_command;
                    n_frame = i_addr >> PG_W;
                    n_st = rcfa_pkg::ST_OK;
                    n_fa = '0;
                    n_rc = '0;
                    case (i_command)
                        rcfa_pkg::CMD_ALLOC: begin
                            n_w = r_hint;
                            n_state = rcfa_pkg::S_SCAN_RD;
                        end
                        rcfa_pkg::CMD_FREE, rcfa_pkg::CMD_REF,
                        rcfa_pkg::CMD_QUERY: begin
                            n_state = rcfa_pkg::S_LOOK;
                        end
                        rcfa_pkg::CMD_INIT: begin
                            n_sw_fc = fc;
                            n_sw_rs = rs;
                            n_init_rsp = 1'b1;
                            n_idx = '0;
                            n_state = rcfa_pkg::S_CLEAR;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            rcfa_pkg::S_SCAN_RD: begin
                if (32'(r_w) >= wlim) begin
                    n_st = rcfa_pkg::ST_OOM;
                    n_fa = rcfa_pkg::ADDR_NONE;
                    n_done = 1'b1;
                    n_state = rcfa_pkg::S_IDLE;
                end else begin
                    n_state = rcfa_pkg::S_SCAN_CHK;
                end
            end
            rcfa_pkg::S_SCAN_CHK: begin
                n_nf = (32'(r_w) << WB_W) | 32'(zpos);
                if (bm_rdata == WORD_FULL) begin
                    n_w = r_w + (NW_W + 1)'(1);
                    n_state = rcfa_pkg::S_SCAN_RD;
                end else begin
                    n_hint = r_w;
                    if (n_nf < 32'(fc)) begin
                        bm_we = 1'b1;
                        bm_waddr = r_w[NW_W-1:0];
                        bm_wdata = bm_rdata | (WORD_BITS'(1) << zpos);
                        n_state = rcfa_pkg::S_ALLOC_WR;
                    end else begin
                        n_st = rcfa_pkg::ST_OOM;
                        n_fa = rcfa_pkg::ADDR_NONE;
                        n_done = 1'b1;
                        n_state = rcfa_pkg::S_IDLE;
                    end
                end
            end
            rcfa_pkg::S_ALLOC_WR: begin
                ct_we = 1'b1;
                ct_waddr = FW'(r_nf);
                ct_wdata = 8'd1;
                if (ct_rdata > 8'd1 && r_shared != '0) begin
                    n_shared = r_shared - 16'd1;
                end
                if (r_used != rcfa_pkg::TOT_MAX) begin
                    n_used = r_used + 16'd1;
                end
                n_fa = r_nf << PG_W;
                n_rc = 8'd1;
                n_done = 1'b1;
                n_state = rcfa_pkg::S_IDLE;
            end
            rcfa_pkg::S_LOOK: begin
                n_state = rcfa_pkg::S_EXEC;
            end
            rcfa_pkg::S_EXEC: begin
                n_done = 1'b1;
                n_state = rcfa_pkg::S_IDLE;
                if (r_cmd == rcfa_pkg::CMD_QUERY) begin
                    if (!in_fc) begin
                        n_st = rcfa_pkg::ST_IGNORED;
                    end else begin
                        n_rc = ct_rdata;
                    end
                end else if (out_rng) begin
                    n_st = rcfa_pkg::ST_IGNORED;
                    n_rc = in_fc ? ct_rdata : 8'd0;
                end else if (!bm_rdata[fbit]) begin
                    n_st = rcfa_pkg::ST_NOT_ALC;
                    n_rc = ct_rdata;
                end else if (r_cmd == rcfa_pkg::CMD_FREE) begin
                    ct_we = 1'b1;
                    if (ct_rdata > 8'd1) begin
                        ct_wdata = ct_rdata - 8'd1;
                        if (ct_rdata == 8'd2 && r_shared != '0) begin
                            n_shared = r_shared - 16'd1;
                        end
                    end else begin
                        ct_wdata = 8'd0;
                        bm_we = 1'b1;
                        bm_wdata = bm_rdata & ~(WORD_BITS'(1) << fbit);
                        if (r_used != '0) begin
                            n_used = r_used - 16'd1;
                        end
                        if ({1'b0, fword} < r_hint) begin
                            n_hint = {1'b0, fword};
                        end
                    end
                    n_rc = ct_wdata;
                end else begin
                    if (ct_rdata == rcfa_pkg::CNT_MAX) begin
                        n_st = rcfa_pkg::ST_SAT;
                        n_rc = rcfa_pkg::CNT_MAX;
                    end else begin
                        ct_we = 1'b1;
                        ct_wdata = c0 + 8'd1;
                        if (c0 == 8'd1 && r_shared != rcfa_pkg::TOT_MAX) begin
                            n_shared = r_shared + 16'd1;
                        end
                        n_rc = ct_wdata;
                    end
                end
            end
            default: begin
                n_state = rcfa_pkg::S_IDLE;
            end
        endcase
    end

    assign fb_diff = (r_used >= fc) ? 16'd0 : fc - r_used;
    assign fb_wide = 48'(fb_diff) << PG_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcfa_pkg::S_CLEAR;
            r_frame_count <= rcfa_pkg::RST_FRAME_COUNT;
            r_reserved <= rcfa_pkg::RST_RESERVED;
            r_low_guard <= rcfa_pkg::RST_LOW_GUARD;
            r_sw_fc <= (32'(rcfa_pkg::RST_FRAME_COUNT) < MAX_FRAMES)
                     ? rcfa_pkg::RST_FRAME_COUNT : 16'(MAX_FRAMES);
            r_sw_rs <= (32'(rcfa_pkg::RST_RESERVED) < MAX_FRAMES)
                     ? rcfa_pkg::RST_RESERVED : 16'(MAX_FRAMES);
            r_init_rsp <= 1'b0;
            r_idx <= '0;
            r_hint <= '0;
            r_used <= '0;
            r_shared <= '0;
            r_done <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sw_fc <= n_sw_fc;
            r_sw_rs <= n_sw_rs;
            r_init_rsp <= n_init_rsp;
            r_idx <= n_idx;
            r_hint <= n_hint;
            r_used <= n_used;
            r_shared <= n_shared;
            r_done <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rcfa_pkg::REG_FRAME_COUNT: r_frame_count <= i_cfg_data;
                    rcfa_pkg::REG_RESERVED:    r_reserved <= i_cfg_data;
                    rcfa_pkg::REG_LOW_GUARD:   r_low_guard <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_frame <= n_frame;
        r_w <= n_w;
        r_nf <= n_nf;
        r_st <= n_st;
        r_fa <= n_fa;
        r_rc <= n_rc;
        if (load_out) begin
            r_o_st <= r_st;
            r_o_fa <= r_fa;
            r_o_rc <= r_rc;
            r_o_fb <= (fb_wide > 48'(rcfa_pkg::FB_MAX)) ? rcfa_pkg::FB_MAX
                                                       : fb_wide[27:0];
            r_o_sh <= r_shared;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_status = r_o_st;
    assign o_frame_addr = r_o_fa;
    assign o_ref_count = r_o_rc;
    assign o_free_bytes = r_o_fb;
    assign o_shared_frames = r_o_sh;

endmodule

### bench/refcounted_frame_allocator_tb.sv
module refcounted_frame_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXF   = 32768;
    localparam int PAGE   = 4096;
    localparam int NWORD  = MAXF / 32;
    localparam int LIMIT  = 6000000;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] fa;
        logic [7:0]  rc;
        logic [27:0] fb;
        logic [15:0] sh;
    } t_frame_result;

    typedef struct {
        t_frame_result r;
        bit            pin;
        logic [2:0]    pst;
        logic [31:0]   pfa;
        logic [7:0]    prc;
    } t_pending;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] addr;
        bit          pin;
        logic [2:0]  st;
        logic [31:0] fa;
        logic [7:0]  rc;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_command;
    logic [31:0] i_addr;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [31:0] o_frame_addr;
    logic [7:0]  o_ref_count;
    logic [27:0] o_free_bytes;
    logic [15:0] o_shared_frames;

    refcounted_frame_allocator dut (.*);

    logic [31:0] map_words [NWORD];
    logic [7:0]  owner_cnt [MAXF];
    int unsigned scan_hint;
    int unsigned used_total;
    int unsigned shared_total;
    logic [15:0] fc_reg;
    logic [15:0] rsv_reg;
    logic [15:0] guard_reg;

    t_pending    expected_q[$];
    int unsigned live_frames[$];
    int          errors;
    int          sent;
    int          checked;
    int          inits;
    int          oom_seen;
    int          sat_seen;
    longint      cycles;
    int          burst_left;
    int          stall_mode;
    t_dir_row    dir_tab[];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int unsigned eff_frames();
        return (fc_reg > MAXF) ? MAXF : fc_reg;
    endfunction

    function automatic void rebuild_map();
        int unsigned fc;
        int unsigned rs;
        fc = eff_frames();
        rs = (rsv_reg < fc) ? rsv_reg : fc;
        for (int w = 0; w < NWORD; w++) map_words[w] = '1;
        for (int f = 0; f < MAXF; f++) begin
            owner_cnt[f] = (f < rs) ? 8'd1 : 8'd0;
            if (f >= rs && f < fc) map_words[f / 32][f % 32] = 1'b0;
        end
        scan_hint    = rs / 32;
        used_total   = rs;
        shared_total = 0;
    endfunction

    function automatic t_frame_result predict_frame_op(logic [2:0] cmd, logic [31:0] addr);
        t_frame_result r;
        int unsigned   fc;
        int unsigned   wlim;
        int unsigned   nf;
        int unsigned   f;
        bit            found;
        longint        fb;
        fc    = eff_frames();
        f     = addr / PAGE;
        r     = '0;
        found = 0;
        nf    = 0;
        if (cmd == rcfa_pkg::CMD_ALLOC) begin
            wlim = (fc + 31) / 32;
            if (wlim > NWORD) wlim = NWORD;
            for (int unsigned w = scan_hint; w < wlim && !found; w++) begin
                if (map_words[w] != '1) begin
                    for (int j = 31; j >= 0; j--)
                        if (!map_words[w][j]) nf = w * 32 + j;
                    scan_hint = w;
                    found = 1;
                end
            end
            if (found && nf < fc) begin
                map_words[nf / 32][nf % 32] = 1'b1;
                if (owner_cnt[nf] > 1 && shared_total > 0) shared_total--;
                owner_cnt[nf] = 8'd1;
                if (used_total < 16'hFFFF) used_total++;
                r.fa = nf * PAGE;
                r.rc = 8'd1;
                live_frames.push_back(nf);
                if (live_frames.size() > 48) void'(live_frames.pop_front());
            end else begin
                r.st = rcfa_pkg::ST_OOM;
                r.fa = rcfa_pkg::ADDR_NONE;
            end
        end else if (cmd == rcfa_pkg::CMD_FREE || cmd == rcfa_pkg::CMD_REF) begin
            if (f < guard_reg || f >= fc) begin
                r.st = rcfa_pkg::ST_IGNORED;
            end else if (!map_words[f / 32][f % 32]) begin
                r.st = rcfa_pkg::ST_NOT_ALC;
            end else if (cmd == rcfa_pkg::CMD_FREE) begin
                if (owner_cnt[f] > 1) begin
                    owner_cnt[f]--;
                    if (owner_cnt[f] == 1 && shared_total > 0) shared_total--;
                end else begin
                    owner_cnt[f] = 8'd0;
                    map_words[f / 32][f % 32] = 1'b0;
                    if (used_total > 0) used_total--;
                    if (f / 32 < scan_hint) scan_hint = f / 32;
                end
            end else if (owner_cnt[f] == rcfa_pkg::CNT_MAX) begin
                r.st = rcfa_pkg::ST_SAT;
            end else begin
                if (owner_cnt[f] == 0) owner_cnt[f] = 8'd1;
                owner_cnt[f]++;
                if (owner_cnt[f] == 2 && shared_total < 16'hFFFF) shared_total++;
            end
            r.rc = (f < fc) ? owner_cnt[f] : 8'd0;
        end else if (cmd == rcfa_pkg::CMD_QUERY) begin
            if (f >= fc) r.st = rcfa_pkg::ST_IGNORED;
            else r.rc = owner_cnt[f];
        end else if (cmd == rcfa_pkg::CMD_INIT) begin
            rebuild_map();
        end
        fc = eff_frames();
        if (used_total >= fc) begin
            fb = 0;
        end else begin
            fb = longint'(fc - used_total) * PAGE;
            if (fb > rcfa_pkg::FB_MAX) fb = rcfa_pkg::FB_MAX;
        end
        r.fb = fb[27:0];
        r.sh = shared_total[15:0];
        if (r.st == rcfa_pkg::ST_OOM) oom_seen++;
        if (r.st == rcfa_pkg::ST_SAT) sat_seen++;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", checked, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("refcounted_frame_allocator regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_pending e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_mode  <= 0;
        end else begin
            if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 9) < 3);
                2: i_out_stall <= ($urandom_range(0, 9) < 8);
                default: i_out_stall <= ~i_out_stall;
            endcase
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("unexpected result status %0d", o_status);
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (o_status !== e.r.st) report_mismatch("status", o_status, e.r.st);
                    if (o_frame_addr !== e.r.fa)
                        report_mismatch("frame_addr", o_frame_addr, e.r.fa);
                    if (o_ref_count !== e.r.rc)
                        report_mismatch("ref_count", o_ref_count, e.r.rc);
                    if (o_free_bytes !== e.r.fb)
                        report_mismatch("free_bytes", o_free_bytes, e.r.fb);
                    if (o_shared_frames !== e.r.sh)
                        report_mismatch("shared_frames", o_shared_frames, e.r.sh);
                    if (e.pin && (e.r.st !== e.pst || e.r.fa !== e.pfa || e.r.rc !== e.prc))
                        report_mismatch("table row", {e.r.st, e.r.rc}, {e.pst, e.prc});
                    checked++;
                end
            end
        end
    end

    task automatic send_op(logic [2:0] cmd, logic [31:0] addr, bit pin = 0,
                           logic [2:0] pst = '0, logic [31:0] pfa = '0,
                           logic [7:0] prc = '0);
        t_pending e;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_addr     <= addr;
        do @(posedge i_clk); while (o_in_stall);
        e.r   = predict_frame_op(cmd, addr);
        e.pin = pin;
        e.pst = pst;
        e.pfa = pfa;
        e.prc = prc;
        expected_q.push_back(e);
        sent++;
        if (cmd == rcfa_pkg::CMD_INIT) inits++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_config(logic [15:0] fc, logic [15:0] rs, logic [15:0] guard);
        logic [15:0] vals[3];
        vals = '{fc, rs, guard};
        for (int k = 0; k < 3; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 2'(k);
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        fc_reg    = fc;
        rsv_reg   = rs;
        guard_reg = guard;
    endtask

    function automatic logic [31:0] pick_addr();
        int unsigned fc;
        int unsigned fr;
        fc = eff_frames();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1, 2: fr = $urandom_range(0, fc + 40);
            3: fr = $urandom_range(0, guard_reg + 2);
            default: fr = (live_frames.size() != 0) ?
                          live_frames[$urandom_range(0, live_frames.size() - 1)] :
                          $urandom_range(0, fc);
        endcase
        return (fr * PAGE) | $urandom_range(0, PAGE - 1);
    endfunction

    task automatic random_ops(int n);
        int unsigned sel;
        logic [2:0]  cmd;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) cmd = rcfa_pkg::CMD_ALLOC;
            else if (sel < 60) cmd = rcfa_pkg::CMD_FREE;
            else if (sel < 82) cmd = rcfa_pkg::CMD_REF;
            else if (sel < 97) cmd = rcfa_pkg::CMD_QUERY;
            else cmd = 3'($urandom_range(5, 7));
            send_op(cmd, pick_addr());
        end
    endtask

    task automatic run_phase(logic [15:0] fc, logic [15:0] rs, logic [15:0] guard,
                             bit do_init, int n);
        drain_results();
        write_config(fc, rs, guard);
        live_frames.delete();
        if (do_init) send_op(rcfa_pkg::CMD_INIT, $urandom());
        random_ops(n);
    endtask

    initial begin
        int unsigned fr;
        errors      = 0;
        sent        = 0;
        checked     = 0;
        inits       = 0;
        oom_seen    = 0;
        sat_seen    = 0;
        cycles      = 0;
        burst_left  = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_command   = '0;
        i_addr      = '0;
        fc_reg      = rcfa_pkg::RST_FRAME_COUNT;
        rsv_reg     = rcfa_pkg::RST_RESERVED;
        guard_reg   = rcfa_pkg::RST_LOW_GUARD;
        rebuild_map();

        dir_tab = '{
            '{rcfa_pkg::CMD_QUERY, 32'h0000_0000, 1, rcfa_pkg::ST_OK, 32'h0, 8'd1},
            '{rcfa_pkg::CMD_ALLOC, 32'h0000_0000, 1, rcfa_pkg::ST_OK, 32'h0040_0000, 8'd1},
            '{rcfa_pkg::CMD_REF,   32'h0040_0FFF, 1, rcfa_pkg::ST_OK, 32'h0, 8'd2},
            '{rcfa_pkg::CMD_FREE,  32'h0040_0000, 1, rcfa_pkg::ST_OK, 32'h0, 8'd1},
            '{rcfa_pkg::CMD_FREE,  32'h0040_0123, 1, rcfa_pkg::ST_OK, 32'h0, 8'd0},
            '{rcfa_pkg::CMD_FREE,  32'h0040_0000, 1, rcfa_pkg::ST_NOT_ALC, 32'h0, 8'd0},
            '{rcfa_pkg::CMD_REF,   32'h0040_0000, 1, rcfa_pkg::ST_NOT_ALC, 32'h0, 8'd0},
            '{rcfa_pkg::CMD_FREE,  32'h0000_0000, 1, rcfa_pkg::ST_IGNORED, 32'h0, 8'd1},
            '{rcfa_pkg::CMD_REF,   32'h000F_F000, 1, rcfa_pkg::ST_IGNORED, 32'h0, 8'd1},
            '{rcfa_pkg::CMD_REF,   32'h0FFF_FFFF, 1, rcfa_pkg::ST_IGNORED, 32'h0, 8'd0},
            '{rcfa_pkg::CMD_QUERY, 32'hFFFF_FFFF, 1, rcfa_pkg::ST_IGNORED, 32'h0, 8'd0},
            '{rcfa_pkg::CMD_QUERY, 32'h07FF_F000, 1, rcfa_pkg::ST_OK, 32'h0, 8'd0},
            '{rcfa_pkg::CMD_REF,   32'h0010_0000, 1, rcfa_pkg::ST_OK, 32'h0, 8'd2},
            '{rcfa_pkg::CMD_FREE,  32'h0010_0000, 1, rcfa_pkg::ST_OK, 32'h0, 8'd1},
            '{3'd5,                32'hAAAA_5555, 1, rcfa_pkg::ST_OK, 32'h0, 8'd0},
            '{3'd6,                32'h5555_AAAA, 1, rcfa_pkg::ST_OK, 32'h0, 8'd0},
            '{3'd7,                32'hFFFF_FFFF, 1, rcfa_pkg::ST_OK, 32'h0, 8'd0},
            '{rcfa_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 0, rcfa_pkg::ST_OK, 32'h0, 8'd0},
            '{rcfa_pkg::CMD_ALLOC, 32'h0,         0, rcfa_pkg::ST_OK, 32'h0, 8'd0},
            '{rcfa_pkg::CMD_REF,   32'h0040_1000, 0, rcfa_pkg::ST_OK, 32'h0, 8'd0},
            '{rcfa_pkg::CMD_INIT,  32'h0,         1, rcfa_pkg::ST_OK, 32'h0, 8'd0},
            '{rcfa_pkg::CMD_QUERY, 32'h0040_1000, 1, rcfa_pkg::ST_OK, 32'h0, 8'd0},
            '{rcfa_pkg::CMD_ALLOC, 32'h0,         1, rcfa_pkg::ST_OK, 32'h0040_0000, 8'd1}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k])
            send_op(dir_tab[k].cmd, dir_tab[k].addr, dir_tab[k].pin,
                    dir_tab[k].st, dir_tab[k].fa, dir_tab[k].rc);
        random_ops(10);

        run_phase(16'd32768, 16'd0, 16'd0, 1, 15);
        run_phase(16'd64, 16'd40, 16'd8, 1, 20);
        send_op(rcfa_pkg::CMD_ALLOC, 32'h0);
        fr = (live_frames.size() != 0) ? live_frames[$] : 40;
        repeat (256) send_op(rcfa_pkg::CMD_REF, fr * PAGE);
        repeat (3) send_op(rcfa_pkg::CMD_FREE, fr * PAGE);
        run_phase(16'd128, 16'd40, 16'd8, 0, 15);
        for (int k = 64; k < 72; k++) send_op(rcfa_pkg::CMD_REF, k * PAGE);
        run_phase(16'd36, 16'd40, 16'd8, 0, 10);
        run_phase(16'd36, 16'd40, 16'd8, 1, 10);
        run_phase(16'd1, 16'd65535, 16'd32768, 1, 6);
        run_phase(16'd32768, 16'd32768, 16'd32768, 1, 6);
        run_phase(16'd32767, 16'd32767, 16'd32767, 1, 6);
        run_phase(16'd32767, 16'd31, 16'd1, 1, 10);
        for (int p = 0; p < 2; p++) begin
            fr = $urandom_range(1, 300);
            run_phase(16'(fr), 16'($urandom_range(0, fr + 20)),
                      16'($urandom_range(0, fr)), $urandom_range(0, 3) != 0, 10);
        end

        drain_results();
        $display("sent %0d transactions, checked %0d results, %0d reinitializations",
                 sent, checked, inits);
        $display("out-of-memory results %0d, saturated references %0d", oom_seen, sat_seen);
        if (errors == 0)
            $display("refcounted_frame_allocator regression: pass");
        else
            $display("refcounted_frame_allocator regression: fail");
        $finish;
    end

endmodule
